@@ sv/rrr_pkg.sv @@
// Shared constants, binomial table and request type for the RRR rank block.
// No dependencies; every other file imports this package.
package rrr_pkg;

    localparam int RRR_MAX_BLOCKS     = 4096;
    localparam int RRR_MAX_BLOCK_BITS = 15;

    localparam int BLK_W = 15;  // width of a stored pattern
    localparam int OFF_W = 13;  // width of a stored offset
    localparam int CLS_W = 4;   // width of a class
    localparam int POS_W = 16;  // bit position / rank width
    localparam int FAC_W = 7;   // superblock factor width

    localparam logic [1:0] CFG_BLOCK_SIZE   = 2'd0;
    localparam logic [1:0] CFG_SUPER_FACTOR = 2'd1;
    localparam logic [1:0] CFG_TOTAL_BITS   = 2'd2;

    typedef logic [15:0][15:0][OFF_W-1:0] binom_tab_t;

    // Pascal's triangle, evaluated at elaboration only.
    function automatic binom_tab_t make_binom();
        binom_tab_t tab;
        tab = '0;
        for (int n = 0; n < 16; n++) begin
            tab[n][0] = OFF_W'(1);
            for (int k = 1; k <= n; k++) begin
                tab[n][k] = tab[n-1][k-1] + ((k < n) ? tab[n-1][k] : OFF_W'(0));
            end
        end
        return tab;
    endfunction

    localparam binom_tab_t BINOM = make_binom();

    typedef struct packed {
        logic             start;
        logic             decode;  // 1: class/offset to pattern, 0: pattern to offset
        logic [CLS_W-1:0] cls;
        logic [OFF_W-1:0] off;
        logic [BLK_W-1:0] bits;
    } enum_req_t;

endpackage

@@ sv/rrr_div.sv @@
// Iterative restoring divider, one quotient bit per cycle.
// Depends on rrr_pkg for widths.
module rrr_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [rrr_pkg::POS_W-1:0]  dividend,
    input  logic [rrr_pkg::FAC_W-1:0]  divisor,
    output logic                       busy,
    output logic [rrr_pkg::POS_W-1:0]  quotient,
    output logic [rrr_pkg::FAC_W-1:0]  remainder
);
    import rrr_pkg::*;

    logic               busy_reg, busy_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic [POS_W-1:0]   q_reg, q_next;
    logic [FAC_W-1:0]   r_reg, r_next;
    logic [FAC_W-1:0]   d_reg, d_next;
    logic [FAC_W:0]     trial;

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        trial     = {r_reg, q_reg[POS_W-1]};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = 5'(POS_W - 1);
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
        end else if (busy_reg) begin
            if (trial >= {1'b0, d_reg}) begin
                r_next = FAC_W'(trial - {1'b0, d_reg});
                q_next = {q_reg[POS_W-2:0], 1'b1};
            end else begin
                r_next = trial[FAC_W-1:0];
                q_next = {q_reg[POS_W-2:0], 1'b0};
            end
            if (cnt_reg == 5'd0) begin
                busy_next = 1'b0;
            end else begin
                cnt_next = cnt_reg - 5'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign busy      = busy_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg;

endmodule

@@ sv/rrr_enum.sv @@
// Enumerative coder: pattern to offset within its class, or back, one bit a cycle.
// Depends on rrr_pkg for the binomial table and request struct.
module rrr_enum #(
    parameter int MAX_BLOCK_BITS = rrr_pkg::RRR_MAX_BLOCK_BITS
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  rrr_pkg::enum_req_t         req,
    output logic                       busy,
    output logic [rrr_pkg::OFF_W-1:0]  off_out,
    output logic [rrr_pkg::BLK_W-1:0]  bits_out
);
    import rrr_pkg::*;

    logic               busy_reg, busy_next;
    logic               dec_reg, dec_next;
    logic [3:0]         p_reg, p_next;
    logic [CLS_W-1:0]   r_reg, r_next;
    logic [OFF_W-1:0]   off_reg, off_next;
    logic [BLK_W-1:0]   bits_reg, bits_next;
    logic [OFF_W-1:0]   coef;

    always_comb begin
        busy_next = busy_reg;
        dec_next  = dec_reg;
        p_next    = p_reg;
        r_next    = r_reg;
        off_next  = off_reg;
        bits_next = bits_reg;
        coef      = BINOM[p_reg][r_reg];
        if (req.start) begin
            busy_next = 1'b1;
            dec_next  = req.decode;
            p_next    = 4'(MAX_BLOCK_BITS - 1);
            if (req.decode) begin
                r_next    = req.cls;
                off_next  = req.off;
                bits_next = '0;
            end else begin
                r_next    = CLS_W'($countones(req.bits));
                off_next  = '0;
                bits_next = req.bits;
            end
        end else if (busy_reg) begin
            if (dec_reg) begin
                if (r_reg != '0 && off_reg >= coef) begin
                    bits_next[p_reg] = 1'b1;
                    off_next         = off_reg - coef;
                    r_next           = r_reg - CLS_W'(1);
                end
            end else if (bits_reg[p_reg]) begin
                off_next = off_reg + coef;
                r_next   = r_reg - CLS_W'(1);
            end
            if (p_reg == 4'd0) begin
                busy_next = 1'b0;
            end else begin
                p_next = p_reg - 4'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
        dec_reg  <= dec_next;
        p_reg    <= p_next;
        r_reg    <= r_next;
        off_reg  <= off_next;
        bits_reg <= bits_next;
    end

    assign busy     = busy_reg;
    assign off_out  = off_reg;
    assign bits_out = bits_reg;

endmodule

@@ sv/rrr_store.sv @@
// Class, offset and superblock memories with registered reads.
// Depends on rrr_pkg for field widths.
module rrr_store #(
    parameter int MAX_BLOCKS = rrr_pkg::RRR_MAX_BLOCKS,
    parameter int AW         = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1
) (
    input  logic                       aclk,
    input  logic                       blk_we,
    input  logic [AW-1:0]              blk_waddr,
    input  logic [rrr_pkg::CLS_W-1:0]  cls_wdata,
    input  logic [rrr_pkg::OFF_W-1:0]  off_wdata,
    input  logic                       sb_we,
    input  logic [AW-1:0]              sb_waddr,
    input  logic [rrr_pkg::POS_W-1:0]  sb_wdata,
    input  logic [AW-1:0]              cls_raddr,
    input  logic [AW-1:0]              off_raddr,
    input  logic [AW-1:0]              sb_raddr,
    output logic [rrr_pkg::CLS_W-1:0]  cls_rdata,
    output logic [rrr_pkg::OFF_W-1:0]  off_rdata,
    output logic [rrr_pkg::POS_W-1:0]  sb_rdata
);
    import rrr_pkg::*;

    logic [CLS_W-1:0] cls_mem [MAX_BLOCKS];
    logic [OFF_W-1:0] off_mem [MAX_BLOCKS];
    logic [POS_W-1:0] sb_mem  [MAX_BLOCKS];

    always_ff @(posedge aclk) begin
        if (blk_we) begin
            cls_mem[blk_waddr] <= cls_wdata;
            off_mem[blk_waddr] <= off_wdata;
        end
        if (sb_we) begin
            sb_mem[sb_waddr] <= sb_wdata;
        end
        cls_rdata <= cls_mem[cls_raddr];
        off_rdata <= off_mem[off_raddr];
        sb_rdata  <= sb_mem[sb_raddr];
    end

endmodule

@@ sv/rrr_bitvector_rank.sv @@
// Top level of the RRR succinct bitvector with rank queries.
// Depends on rrr_pkg, rrr_div, rrr_enum and rrr_store.
//
// Usage. Beats on the s_ channel carry either a block to load (s_tuser low) or a
// rank query (s_tuser high). A load stores the block as class and offset unless the
// store is full, and produces no beat on the m_ channel. A query produces exactly
// one m_ beat with the number of ones at positions 0 through the clamped position.
// The cfg channel writes block_size (index 0), superblock_factor (index 1) and
// total_bits (index 2); it is always ready and should be used only while idle.
//
// Sequence. The block works on one beat at a time. A load runs the 16-step serial
// divider that finds the superblock of the block beside the 15-step offset
// encoder, and the next beat is taken once both are done. A query runs two serial
// divisions, then one class memory read for each of the r preceding blocks of its
// superblock (r from 0 to factor-1) on the single class read port, overlapped with
// the 15-step decoder. The next beat is taken once the result is registered.
//
// Reset clears the control state, the running rank and the load count. The
// memories are not cleared; an entry reads as garbage until it is loaded.
// When the receiver stalls, the finished result waits in the output register
// and the block goes on taking loads; a second query waits at its last step.
module rrr_bitvector_rank #(
    parameter int MAX_BLOCKS     = rrr_pkg::RRR_MAX_BLOCKS,
    parameter int MAX_BLOCK_BITS = rrr_pkg::RRR_MAX_BLOCK_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [14:0] block_bits, [30:15] position, [31] zero
    input  logic        s_tuser,   // [0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] rank_count
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import rrr_pkg::*;

    localparam int AW   = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNTW = $clog2(MAX_BLOCKS + 1);
    localparam logic [3:0] MBB = 4'(MAX_BLOCK_BITS);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_LOAD  = 4'd1;
    localparam logic [3:0] S_QDIV1 = 4'd2;
    localparam logic [3:0] S_QDIV2 = 4'd3;
    localparam logic [3:0] S_QRD   = 4'd4;
    localparam logic [3:0] S_QSUM  = 4'd5;
    localparam logic [3:0] S_QFIN  = 4'd6;

    // Configuration registers.
    logic [3:0]        bsize_reg;
    logic [FAC_W-1:0]  factor_reg;
    logic [POS_W-1:0]  total_reg;

    // Sequencer state.
    logic [3:0]        state_reg, state_next;
    logic [3:0]        t_reg, t_next;
    logic [FAC_W-1:0]  f_reg, f_next;
    logic [BLK_W-1:0]  blk_reg, blk_next;
    logic [POS_W-1:0]  bi_reg, bi_next;
    logic [3:0]        bo_reg, bo_next;
    logic [FAC_W-1:0]  cnt_reg, cnt_next;
    logic [POS_W-1:0]  j_reg, j_next;
    logic [POS_W-1:0]  sum_reg, sum_next;
    logic              pend_reg, pend_next;
    logic              cls_ok_reg, cls_ok_next;
    logic              sb_ok_reg, sb_ok_next;
    logic [POS_W-1:0]  running_reg, running_next;
    logic [CNTW-1:0]   loaded_reg, loaded_next;
    logic              out_valid_reg, out_valid_next;
    logic [POS_W-1:0]  out_data_reg, out_data_next;

    // Derived values.
    logic [3:0]        t_eff;
    logic [FAC_W-1:0]  f_eff;
    logic [BLK_W-1:0]  tmask;
    logic [POS_W-1:0]  pos_in, pos_clamped;
    logic              accept;
    logic [CLS_W-1:0]  load_cls;
    logic [BLK_W-1:0]  dec_masked;
    logic [3:0]        shift;
    logic [BLK_W-1:0]  head_bits;

    // Sub-unit connections.
    logic              div_start;
    logic [POS_W-1:0]  div_dividend;
    logic [FAC_W-1:0]  div_divisor;
    logic              div_busy;
    logic [POS_W-1:0]  div_q;
    logic [FAC_W-1:0]  div_r;
    enum_req_t         enc_req;
    logic              enc_busy;
    logic [OFF_W-1:0]  enc_off;
    logic [BLK_W-1:0]  enc_bits;
    logic              blk_we, sb_we;
    logic [AW-1:0]     cls_raddr, off_raddr, sb_raddr;
    logic [CLS_W-1:0]  cls_rdata;
    logic [OFF_W-1:0]  off_rdata;
    logic [POS_W-1:0]  sb_rdata;

    assign t_eff  = (bsize_reg == 4'd0) ? 4'd1 : ((bsize_reg > MBB) ? MBB : bsize_reg);
    assign f_eff  = (factor_reg == '0) ? FAC_W'(1) : factor_reg;
    assign tmask  = BLK_W'((16'd1 << t_reg) - 16'd1);
    assign pos_in = s_tdata[30:15];
    assign pos_clamped = (total_reg == '0) ? '0 :
                         ((pos_in >= total_reg) ? total_reg - POS_W'(1) : pos_in);

    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign load_cls  = CLS_W'($countones(blk_reg));

    // The leading bo+1 bits of the decoded block, whose ones are counted for the rank.
    assign dec_masked = enc_bits & tmask;
    assign shift      = t_reg - 4'd1 - bo_reg;
    assign head_bits  = dec_masked >> shift;

    always_comb begin
        state_next     = state_reg;
        t_next         = t_reg;
        f_next         = f_reg;
        blk_next       = blk_reg;
        bi_next        = bi_reg;
        bo_next        = bo_reg;
        cnt_next       = cnt_reg;
        j_next         = j_reg;
        sum_next       = sum_reg;
        pend_next      = pend_reg;
        cls_ok_next    = cls_ok_reg;
        sb_ok_next     = sb_ok_reg;
        running_next   = running_reg;
        loaded_next    = loaded_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;

        div_start    = 1'b0;
        div_dividend = POS_W'(loaded_reg);
        div_divisor  = f_eff;
        enc_req      = '0;
        blk_we       = 1'b0;
        sb_we        = 1'b0;
        cls_raddr    = bi_reg[AW-1:0];
        off_raddr    = bi_reg[AW-1:0];
        sb_raddr     = div_q[AW-1:0];

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    t_next   = t_eff;
                    f_next   = f_eff;
                    blk_next = s_tdata[14:0] & BLK_W'((16'd1 << t_eff) - 16'd1);
                    if (!s_tuser) begin
                        if (loaded_reg != CNTW'(MAX_BLOCKS)) begin
                            div_start     = 1'b1;
                            div_dividend  = POS_W'(loaded_reg);
                            div_divisor   = f_eff;
                            enc_req.start = 1'b1;
                            enc_req.bits  = s_tdata[14:0]
                                            & BLK_W'((16'd1 << t_eff) - 16'd1);
                            state_next    = S_LOAD;
                        end
                    end else begin
                        div_start    = 1'b1;
                        div_dividend = pos_clamped;
                        div_divisor  = FAC_W'(t_eff);
                        state_next   = S_QDIV1;
                    end
                end
            end
            S_LOAD: begin
                // Waits until both the superblock index and the block offset are ready.
                if (!div_busy && !enc_busy) begin
                    blk_we       = 1'b1;
                    sb_we        = (div_r == '0);
                    running_next = running_reg + POS_W'(load_cls);
                    loaded_next  = loaded_reg + CNTW'(1);
                    state_next   = S_IDLE;
                end
            end
            S_QDIV1: begin
                if (!div_busy) begin
                    bi_next      = div_q;
                    bo_next      = div_r[3:0];
                    div_start    = 1'b1;
                    div_dividend = div_q;
                    div_divisor  = f_reg;
                    state_next   = S_QDIV2;
                end
            end
            S_QDIV2: begin
                // Remainder is the number of blocks between superblock start and target.
                if (!div_busy) begin
                    cnt_next    = div_r;
                    j_next      = bi_reg - POS_W'(div_r);
                    sb_raddr    = div_q[AW-1:0];
                    cls_ok_next = {1'b0, bi_reg} < 17'(MAX_BLOCKS);
                    sb_ok_next  = {1'b0, div_q} < 17'(MAX_BLOCKS);
                    state_next  = S_QRD;
                end
            end
            S_QRD: begin
                sum_next       = sb_ok_reg ? sb_rdata : '0;
                enc_req.start  = 1'b1;
                enc_req.decode = 1'b1;
                enc_req.cls    = cls_ok_reg ? cls_rdata : '0;
                enc_req.off    = cls_ok_reg ? off_rdata : '0;
                pend_next      = 1'b0;
                state_next     = S_QSUM;
            end
            S_QSUM: begin
                if (pend_reg) begin
                    sum_next = sum_reg + (cls_ok_reg ? POS_W'(cls_rdata) : '0);
                end
                if (cnt_reg != '0) begin
                    cls_raddr   = j_reg[AW-1:0];
                    cls_ok_next = {1'b0, j_reg} < 17'(MAX_BLOCKS);
                    j_next      = j_reg + POS_W'(1);
                    cnt_next    = cnt_reg - FAC_W'(1);
                    pend_next   = 1'b1;
                end else begin
                    pend_next = 1'b0;
                    if (!pend_reg) begin
                        state_next = S_QFIN;
                    end
                end
            end
            S_QFIN: begin
                if (!enc_busy && (!out_valid_reg || m_tready)) begin
                    out_valid_next = 1'b1;
                    out_data_next  = sum_reg + POS_W'($countones(head_bits));
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            running_reg   <= '0;
            loaded_reg    <= '0;
            out_valid_reg <= 1'b0;
            bsize_reg     <= 4'd15;
            factor_reg    <= FAC_W'(16);
            total_reg     <= POS_W'(61440);
        end else begin
            state_reg     <= state_next;
            running_reg   <= running_next;
            loaded_reg    <= loaded_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_BLOCK_SIZE:   bsize_reg  <= cfg_data[3:0];
                    CFG_SUPER_FACTOR: factor_reg <= cfg_data[FAC_W-1:0];
                    CFG_TOTAL_BITS:   total_reg  <= cfg_data;
                    default:          ;
                endcase
            end
        end
        t_reg        <= t_next;
        f_reg        <= f_next;
        blk_reg      <= blk_next;
        bi_reg       <= bi_next;
        bo_reg       <= bo_next;
        cnt_reg      <= cnt_next;
        j_reg        <= j_next;
        sum_reg      <= sum_next;
        pend_reg     <= pend_next;
        cls_ok_reg   <= cls_ok_next;
        sb_ok_reg    <= sb_ok_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    rrr_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .busy      (div_busy),
        .quotient  (div_q),
        .remainder (div_r)
    );

    rrr_enum #(
        .MAX_BLOCK_BITS (MAX_BLOCK_BITS)
    ) u_enum (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (enc_req),
        .busy     (enc_busy),
        .off_out  (enc_off),
        .bits_out (enc_bits)
    );

    rrr_store #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .AW         (AW)
    ) u_store (
        .aclk      (aclk),
        .blk_we    (blk_we),
        .blk_waddr (loaded_reg[AW-1:0]),
        .cls_wdata (load_cls),
        .off_wdata (enc_off),
        .sb_we     (sb_we),
        .sb_waddr  (div_q[AW-1:0]),
        .sb_wdata  (running_reg),
        .cls_raddr (cls_raddr),
        .off_raddr (off_raddr),
        .sb_raddr  (sb_raddr),
        .cls_rdata (cls_rdata),
        .off_rdata (off_rdata),
        .sb_rdata  (sb_rdata)
    );

    // The divider and the coder are only started when they are free.
    a_div_free: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");

    a_enum_free: assert property (@(posedge aclk) disable iff (!aresetn)
        enc_req.start |-> !enc_busy)
        else $error("coder restarted while busy");

    // The load count never passes the capacity.
    a_capacity: assert property (@(posedge aclk) disable iff (!aresetn)
        loaded_reg <= CNTW'(MAX_BLOCKS))
        else $error("load count past capacity");

    // A pending result is never overwritten.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready) |=> out_valid_reg && $stable(out_data_reg))
        else $error("pending result lost");

endmodule

@@ bench/rrr_bitvector_rank_tb.sv @@
// Self-checking testbench for the RRR bitvector rank block (rrr_bitvector_rank).
// Depends on rrr_pkg and the block's RTL; it keeps its own rank predictor.
`timescale 1ns / 100ps

module rrr_bitvector_rank_tb;
    import rrr_pkg::*;

    // Codes carried in s_tuser.
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // Cycles to let a load finish after the last result.
    localparam int SETTLE_CYCLES = 150;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;
    logic        s_tuser   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data  = '0;

    rrr_bitvector_rank dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Predictor state: the shadow copy of what the block has stored.
    // Patterns are kept as loaded (already masked to t), since decoding the
    // class and offset gives back exactly that pattern.
    logic [14:0] pattern_shadow [RRR_MAX_BLOCKS];
    logic [15:0] prefix_shadow  [RRR_MAX_BLOCKS];
    bit          prefix_written [RRR_MAX_BLOCKS];
    int          blocks_stored;
    logic [15:0] ones_so_far;

    // Shadow configuration registers.
    logic [3:0]  bits_per_block;
    logic [6:0]  blocks_per_super;
    logic [15:0] vector_length;

    logic [15:0] rank_q [$];   // expected rank counts, oldest first

    int  errors       = 0;
    int  loads_sent   = 0;
    int  loads_dropped = 0;
    int  queries_sent = 0;
    int  ranks_seen   = 0;
    int  cfg_writes   = 0;
    bit  tx_idle      = 1'b1;  // sender inserts random gaps when set
    bit  rx_idle      = 1'b1;  // receiver inserts random stalls when set
    int  rx_stall     = 0;

    function automatic int ones15(input logic [14:0] v);
        int c;
        c = 0;
        for (int k = 0; k < 15; k++) c += v[k];
        return c;
    endfunction

    function automatic int width_t();
        return (bits_per_block == 0) ? 1 : int'(bits_per_block);
    endfunction

    function automatic int factor_f();
        return (blocks_per_super == 0) ? 1 : int'(blocks_per_super);
    endfunction

    // Position after the length clamp.
    function automatic int clamp_pos(input logic [15:0] pos);
        if (vector_length == 0) return 0;
        if (pos >= vector_length) return int'(vector_length) - 1;
        return int'(pos);
    endfunction

    // A query is only legal when every store entry it reads has been written:
    // the target block and the superblock prefix it starts from.
    function automatic bit query_legal(input logic [15:0] pos);
        int i, bi, si;
        i  = clamp_pos(pos);
        bi = i / width_t();
        si = bi / factor_f();
        return (bi < blocks_stored) && (si < RRR_MAX_BLOCKS) && prefix_written[si];
    endfunction

    function automatic logic [15:0] rank_of(input logic [15:0] pos);
        int          i, t, f, bi, si, bo;
        logic [15:0] sum;
        logic [14:0] pat, tmask;
        t     = width_t();
        f     = factor_f();
        i     = clamp_pos(pos);
        bi    = i / t;
        si    = bi / f;
        bo    = i % t;
        tmask = 15'((32'd1 << t) - 1);
        sum   = prefix_shadow[si];
        for (int j = si * f; j < bi; j++) sum += 16'(ones15(pattern_shadow[j]));
        pat = pattern_shadow[bi] & tmask;
        sum += 16'(ones15(pat >> (t - 1 - bo)));
        return sum;
    endfunction

    // Update the shadow state for one accepted beat.
    task automatic track_beat(input logic kind, input logic [14:0] bits,
                              input logic [15:0] pos);
        logic [14:0] blk;
        if (kind == KIND_QUERY) begin
            rank_q.insert(rank_q.size(), rank_of(pos));
            queries_sent++;
        end else if (blocks_stored >= RRR_MAX_BLOCKS) begin
            loads_dropped++;
        end else begin
            blk = bits & 15'((32'd1 << width_t()) - 1);
            if (blocks_stored % factor_f() == 0) begin
                prefix_shadow[blocks_stored / factor_f()]  = ones_so_far;
                prefix_written[blocks_stored / factor_f()] = 1'b1;
            end
            pattern_shadow[blocks_stored] = blk;
            ones_so_far += 16'(ones15(blk));
            blocks_stored++;
            loads_sent++;
        end
    endtask

    // Send one beat on the s_ channel, with a random lead-in gap.
    task automatic send_beat(input logic kind, input logic [14:0] bits,
                             input logic [15:0] pos);
        int gap;
        gap = tx_idle ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {1'b0, pos, bits};
        do @(posedge aclk); while (!s_tready);
        track_beat(kind, bits, pos);
    endtask

    task automatic load_block(input logic [14:0] bits);
        send_beat(KIND_LOAD, bits, 16'($urandom));
    endtask

    task automatic query_rank(input logic [15:0] pos);
        send_beat(KIND_QUERY, 15'($urandom), pos);
    endtask

    // Hold the sender until every expected rank has come back, then let any
    // load still in flight finish.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (rank_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (index)
            CFG_BLOCK_SIZE:   bits_per_block   = value[3:0];
            CFG_SUPER_FACTOR: blocks_per_super = value[6:0];
            CFG_TOTAL_BITS:   vector_length    = value;
            default: ;
        endcase
        cfg_writes++;
    endtask

    task automatic set_config(input int t, input int f, input int n);
        drain_results();
        write_reg(CFG_BLOCK_SIZE, 16'(t));
        write_reg(CFG_SUPER_FACTOR, 16'(f));
        write_reg(CFG_TOTAL_BITS, 16'(n));
    endtask

    // Pick a query position that reads only written entries; most land inside
    // the loaded blocks, some are raw 16-bit values or past the end.
    task automatic random_query_or_load();
        logic [15:0] pos;
        int          bi;
        bit          found;
        found = 1'b0;
        for (int k = 0; k < 20 && !found && blocks_stored > 0; k++) begin
            case ($urandom_range(0, 9))
                0, 1:    pos = 16'($urandom);
                2:       pos = 16'($urandom_range(int'(vector_length), 65535));
                default: begin
                    bi  = $urandom_range(0, blocks_stored - 1);
                    pos = 16'(bi * width_t() + $urandom_range(0, width_t() - 1));
                end
            endcase
            found = query_legal(pos);
        end
        if (found) query_rank(pos);
        else load_block(15'($urandom));
    endtask

    task automatic random_phase(input int items, input int load_pct);
        for (int k = 0; k < items; k++) begin
            // Stretches without idling on either side.
            if (k % 64 == 0) begin
                tx_idle = ($urandom_range(0, 3) != 0);
                rx_idle = ($urandom_range(0, 3) != 0);
            end
            if ($urandom_range(1, 100) <= load_pct) load_block(15'($urandom));
            else random_query_or_load();
        end
    endtask

    // Extremes of the block pattern at the default configuration: empty and
    // full blocks, single bits at either end, and queries at block edges.
    task automatic test_directed_defaults();
        load_block(15'h7FFF);
        load_block(15'h0000);
        load_block(15'h4000);
        load_block(15'h0001);
        load_block(15'h5555);
        query_rank(16'd0);
        query_rank(16'd14);
        query_rank(16'd15);
        query_rank(16'd44);
        query_rank(16'd74);
    endtask

    // Odd register values: block size and factor of zero, a zero length,
    // positions past the end, and block bits above t that must be masked.
    task automatic test_directed_odd_config();
        set_config(0, 0, 0);
        load_block(15'h7FFF);        // only the lowest bit survives at t=1
        query_rank(16'd1234);        // zero length: treated as position 0
        query_rank(16'hFFFF);
        drain_results();
        write_reg(CFG_TOTAL_BITS, 16'd6);
        query_rank(16'hFFFF);        // clamps to the last bit, block 5
        query_rank(16'd5);           // the same bit by its own index
        drain_results();
        write_reg(CFG_BLOCK_SIZE, 16'd4);
        load_block(15'h7FFF);        // masked to 4'hF, stored as block 6
        drain_results();
        write_reg(CFG_TOTAL_BITS, 16'd61440);
        query_rank(16'd24);
        query_rank(16'd25);
        query_rank(16'd27);
    endtask

    // Fixed settings, including zero and maximum values, then random ones, with loads
    // first so fresh superblock prefixes exist under each factor.
    task automatic test_random_settings();
        int settings [7][3] = '{
            '{15, 16, 61440}, '{1, 1, 300}, '{15, 64, 61440}, '{7, 127, 1000},
            '{3, 5, 0}, '{15, 1, 65535}, '{0, 64, 1}
        };
        for (int p = 0; p < 7; p++) begin
            set_config(settings[p][0], settings[p][1], settings[p][2]);
            random_phase(8, 100);
            random_phase(150, 40);
            if (p == 1) begin
                drain_results();     // sender holds until all ranks are back
                random_phase(50, 40);
            end
        end
        for (int p = 0; p < 3; p++) begin
            set_config($urandom_range(0, 15), $urandom_range(0, 127),
                       $urandom_range(0, 65535));
            random_phase(8, 100);
            random_phase(120, 40);
        end
    endtask

    // Receiver side: a random stall after each accepted rank.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            rx_stall = rx_idle ? $urandom_range(0, 3) : 0;
        end else if (rx_stall > 0) begin
            rx_stall--;
        end
        m_tready <= aresetn && (rx_stall == 0);
    end

    // Checker: each rank beat against the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            ranks_seen++;
            if (rank_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected rank beat: actual %0d", m_tdata);
            end else begin
                logic [15:0] want;
                want = rank_q.pop_front();
                if (m_tdata !== want) begin
                    errors++;
                    if (errors <= 10)
                        $display("rank_count mismatch: expected %0d actual %0d",
                                 want, m_tdata);
                end
            end
        end
    end

    initial begin
        blocks_stored    = 0;
        ones_so_far      = '0;
        bits_per_block   = 4'd15;
        blocks_per_super = 7'd16;
        vector_length    = 16'd61440;
        for (int k = 0; k < RRR_MAX_BLOCKS; k++) prefix_written[k] = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_defaults();
        test_directed_odd_config();
        test_random_settings();
        drain_results();

        $display("Covered %0d loads (%0d dropped at capacity), %0d rank queries, %0d ranks",
                 loads_sent, loads_dropped, queries_sent, ranks_seen);
        $display("checked over %0d register writes incl. zero and maximum settings",
                 cfg_writes);
        if (errors == 0 && rank_q.size() == 0) begin
            $display("rrr_bitvector_rank test passed");
        end else begin
            $display("rrr_bitvector_rank test failed");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial begin
        #50_000_000;
        $display("rrr_bitvector_rank test failed");
        $finish;
    end

endmodule
